FILE: hdl/autocorrelation_engine_macros.svh
// Assertion helpers for the autocorrelation engine checks
`ifndef AUTOCORRELATION_ENGINE_MACROS_SVH
`define AUTOCORRELATION_ENGINE_MACROS_SVH

// Check a property while out of reset
`define ACOR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define ACOR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/acor_pkg.sv
package acor_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int LAG_BITS      = 6;
    localparam int CORR_BITS     = 16;
    localparam int LAGCNT_BITS   = 7;
    localparam int ACC_BITS      = 64;
    localparam int FRAC_STEPS    = 15;
    localparam int STEP_BITS     = 4;

    localparam logic [LAGCNT_BITS-1:0] LAG_COUNT_RESET = 7'd16;
    localparam logic [CORR_BITS-1:0]   Q_ONE           = 16'd16384;
    localparam logic [CORR_BITS-1:0]   Q_SAT           = 16'd32768;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    typedef struct packed
    {
        logic idle;
        logic q_empty;
        logic q_full;
    } back_status_t;

endpackage

FILE: hdl/acor_queue.sv
module acor_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/acor_front.sv
module acor_front #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [acor_pkg::SAMPLE_BITS-1:0]  s_tdata,
    input  logic                              s_tlast,
    input  acor_pkg::back_status_t            status,
    output logic                              wr_en,
    output logic [$clog2(MAX_SAMPLES)-1:0]    wr_addr,
    output logic [acor_pkg::SAMPLE_BITS-1:0]  wr_data,
    output logic                              push,
    output logic [2*$clog2(MAX_SAMPLES+1)+acor_pkg::SAMPLE_BITS-1:0] push_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = acor_pkg::SAMPLE_BITS + CW;

    logic [CW-1:0]        count_reg, count_next, cnt_new;
    logic signed [SW-1:0] sum_reg, sum_next, sum_new;
    logic                 accept;
    logic                 room;
    logic signed [acor_pkg::SAMPLE_BITS-1:0] x;

    assign s_tready  = status.idle && status.q_empty && !status.q_full;
    assign accept    = s_tvalid && s_tready;
    assign room      = (32'(count_reg) < MAX_SAMPLES);
    assign x         = signed'(s_tdata);
    assign wr_en     = accept && room;
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_data   = s_tdata;
    assign push      = accept && s_tlast;
    assign push_data = {sum_new, cnt_new};

    always_comb
    begin
        cnt_new = count_reg;
        sum_new = sum_reg;
        if (room)
        begin
            cnt_new = count_reg + CW'(1);
            sum_new = sum_reg + SW'(x);
        end
        count_next = count_reg;
        sum_next   = sum_reg;
        if (accept)
        begin
            count_next = s_tlast ? '0 : cnt_new;
            sum_next   = s_tlast ? '0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

FILE: hdl/acor_back.sv
module acor_back #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_LAGS    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acor_pkg::LAGCNT_BITS-1:0]  cfg_data,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_SAMPLES)-1:0]    wr_addr,
    input  logic [acor_pkg::SAMPLE_BITS-1:0]  wr_data,
    input  logic                              job_valid,
    input  logic [2*$clog2(MAX_SAMPLES+1)+acor_pkg::SAMPLE_BITS-1:0] job_data,
    output logic                              pop,
    output logic                              idle,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = acor_pkg::SAMPLE_BITS + CW;
    localparam int DW = CW + 18;
    localparam int PW = 2 * DW;
    localparam int LB = acor_pkg::LAG_BITS;
    localparam int LC = acor_pkg::LAGCNT_BITS;
    localparam int QB = acor_pkg::CORR_BITS;
    localparam int XB = acor_pkg::ACC_BITS;

    logic [acor_pkg::SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

    acor_pkg::back_state_t state_reg, state_next;

    logic [LC-1:0]         lag_count_reg;
    logic [CW-1:0]         n_reg, n_next;
    logic signed [SW-1:0]  s_reg, s_next;
    logic [LC-1:0]         lags_reg, lags_next;
    logic [LB-1:0]         k_reg, k_next;
    logic [AW-1:0]         i_reg, i_next;
    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [acor_pkg::SAMPLE_BITS-1:0] ra_reg, rb_reg;
    logic signed [DW-1:0]  da_reg, db_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [XB-1:0]         acc_reg, acc_next;
    logic [XB-1:0]         den_reg, den_next;
    logic                  zv_reg, zv_next;
    logic [XB-1:0]         r_reg, r_next;
    logic [QB-1:0]         q_reg, q_next;
    logic [acor_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic [QB-1:0]         corr_reg, corr_next;

    logic                  out_valid_reg, out_valid_next;
    logic [LB-1:0]         out_lag_reg;
    logic [QB-1:0]         out_corr_reg;
    logic                  out_zv_reg, out_last_reg;
    logic                  out_load;

    logic signed [DW-1:0]  n_s, s_s;
    logic [XB-1:0]         num_sel, den_sel, mag;
    logic [XB:0]           r2;
    logic [QB-1:0]         q_cap;
    logic [QB:0]           q_half;
    logic [QB-1:0]         q_mag;
    logic [LC-1:0]         lag_clamp;
    logic [LB-1:0]         k_inc;
    logic                  free_out;
    logic                  last_lag;

    assign cfg_ready = 1'b1;
    assign idle      = (state_reg == acor_pkg::ST_IDLE);
    assign n_s       = signed'(DW'(n_reg));
    assign s_s       = DW'(s_reg);
    assign free_out  = !out_valid_reg || m_tready;
    assign k_inc     = k_reg + LB'(1);
    assign last_lag  = ((LC'(k_reg) + LC'(1)) == lags_reg);

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_corr_reg, out_lag_reg};
    assign m_tuser   = out_zv_reg;
    assign m_tlast   = out_last_reg;

    always_comb
    begin
        if (lag_count_reg == '0)
        begin
            lag_clamp = LC'(1);
        end
        else if (32'(lag_count_reg) > MAX_LAGS)
        begin
            lag_clamp = LC'(MAX_LAGS);
        end
        else
        begin
            lag_clamp = lag_count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        ra_reg   <= signed'(mem[i_reg]);
        rb_reg   <= signed'(mem[AW'(i_reg + AW'(k_reg))]);
        da_reg   <= n_s * DW'(ra_reg) - s_s;
        db_reg   <= n_s * DW'(rb_reg) - s_s;
        prod_reg <= PW'(da_reg) * PW'(db_reg);
    end

    always_comb
    begin
        num_sel = acc_reg;
        den_sel = (k_reg == '0) ? acc_reg : den_reg;
        mag     = num_sel[XB-1] ? (XB'(0) - num_sel) : num_sel;
        r2      = {r_reg, 1'b0};
        q_cap   = (q_reg > acor_pkg::Q_SAT) ? acor_pkg::Q_SAT : q_reg;
        q_half  = ({1'b0, q_cap} + (QB+1)'(1)) >> 1;
        q_mag   = (q_half > {1'b0, acor_pkg::Q_ONE}) ? acor_pkg::Q_ONE : q_half[QB-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        lags_next      = lags_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        acc_next       = v3_reg ? (acc_reg + XB'(prod_reg)) : acc_reg;
        den_next       = den_reg;
        zv_next        = zv_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        corr_next      = corr_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            acor_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    n_next     = job_data[CW-1:0];
                    s_next     = signed'(job_data[CW+SW-1:CW]);
                    lags_next  = lag_clamp;
                    k_next     = '0;
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = acor_pkg::ST_ACC;
                end
            end
            acor_pkg::ST_ACC:
            begin
                i_next = i_reg + AW'(1);
                if (CW'(i_reg) == (n_reg - CW'(k_reg) - CW'(1)))
                begin
                    state_next = acor_pkg::ST_DRAIN;
                end
            end
            acor_pkg::ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    if (k_reg == '0)
                    begin
                        den_next = acc_reg;
                        zv_next  = (acc_reg == '0);
                    end
                    if (den_sel == '0)
                    begin
                        corr_next  = '0;
                        state_next = acor_pkg::ST_EMIT;
                    end
                    else
                    begin
                        neg_next   = num_sel[XB-1];
                        state_next = acor_pkg::ST_DIV;
                        if ({1'b0, mag} >= {den_sel, 1'b0})
                        begin
                            q_next    = acor_pkg::Q_SAT;
                            step_next = '0;
                        end
                        else
                        begin
                            q_next    = (mag >= den_sel) ? QB'(1) : '0;
                            r_next    = (mag >= den_sel) ? (mag - den_sel) : mag;
                            step_next = acor_pkg::STEP_BITS'(acor_pkg::FRAC_STEPS);
                        end
                    end
                end
            end
            acor_pkg::ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    corr_next  = neg_reg ? (QB'(0) - q_mag) : q_mag;
                    state_next = acor_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg - acor_pkg::STEP_BITS'(1);
                    if (r2 >= {1'b0, den_reg})
                    begin
                        r_next = XB'(r2 - {1'b0, den_reg});
                        q_next = {q_reg[QB-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = r2[XB-1:0];
                        q_next = {q_reg[QB-2:0], 1'b0};
                    end
                end
            end
            acor_pkg::ST_EMIT:
            begin
                if (free_out)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (last_lag)
                    begin
                        state_next = acor_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_inc;
                        if (zv_reg || (32'(k_inc) >= 32'(n_reg)))
                        begin
                            corr_next = '0;
                        end
                        else
                        begin
                            i_next     = '0;
                            acc_next   = '0;
                            state_next = acor_pkg::ST_ACC;
                        end
                    end
                end
            end
            default:
            begin
                state_next = acor_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acor_pkg::ST_IDLE;
            lag_count_reg <= acor_pkg::LAG_COUNT_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                lag_count_reg <= cfg_data;
            end
            v1_reg        <= (state_reg == acor_pkg::ST_ACC);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        s_reg    <= s_next;
        lags_reg <= lags_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        acc_reg  <= acc_next;
        den_reg  <= den_next;
        zv_reg   <= zv_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
        corr_reg <= corr_next;
        if (out_load)
        begin
            out_lag_reg  <= k_reg;
            out_corr_reg <= corr_reg;
            out_zv_reg   <= zv_reg;
            out_last_reg <= last_lag;
        end
    end

endmodule

FILE: hdl/autocorrelation_engine.sv
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | tdata sample, tlast series end
// m_      | out       | m_tvalid/m_tready  | tdata lag, correlation; tuser; tlast
// cfg_    | in        | cfg_valid/cfg_ready| cfg_data lag_count
//
// Samples load at one request per cycle into the sample store while the back end is idle with no job queued.
// After the series end each lag k streams n-k sample pairs through the dual-read store port,
// drains the multiply-accumulate, runs the serial divider and is handed over to the output.
// Zero variance skips the divider; lags at or beyond n or after it are emitted as zero.
// Reset clears the state machine, valid flags and counters and sets the lag count to 16; the store needs no clearing.
// s_tready stays low from series end until the final lag is handed over.
module autocorrelation_engine #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_LAGS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] lag_index, [21:6] correlation
    output logic        m_tuser,   // [0] zero_variance
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int JW = 2 * $clog2(MAX_SAMPLES + 1) + acor_pkg::SAMPLE_BITS;

    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [acor_pkg::SAMPLE_BITS-1:0] wr_data;
    logic                             push, pop, q_full, q_empty, back_idle;
    logic [JW-1:0]                    push_data, pop_data;
    acor_pkg::back_status_t           status;

    assign status.idle    = back_idle;
    assign status.q_empty = q_empty;
    assign status.q_full  = q_full;

    acor_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .status    (status),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_data (push_data)
    );

    acor_queue #(
        .WIDTH(JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    acor_back #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .MAX_LAGS   (MAX_LAGS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (!q_empty),
        .job_data  (pop_data),
        .pop       (pop),
        .idle      (back_idle),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hdl/acor_checker.sv
`include "autocorrelation_engine_macros.svh"

module acor_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `ACOR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `ACOR_ASSERT(a_zv_zero, m_tvalid && m_tuser |-> m_tdata[21:6] == 16'd0, "zero variance with non-zero value")
    `ACOR_ASSERT(a_lag0_one, m_tvalid && m_tdata[5:0] == 6'd0 && !m_tuser |-> m_tdata[21:6] == 16'h4000, "lag 0 not unity")
    `ACOR_ASSERT(a_no_load, m_tvalid && !m_tlast |-> !s_tready, "sample taken mid-series output")
    `ACOR_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind autocorrelation_engine acor_checker u_acor_checker (.*);
